// ----- src/ddf_pkg.sv -----
// ddf_pkg: shared types and constants for the degenerate facet filter.
// Used by the channel interfaces, the entry memory and the top level.
package ddf_pkg;

    localparam int unsigned REF_W        = 24;
    localparam int unsigned DROP_W       = 32;
    localparam int unsigned MIN_DISTINCT = 3;

    // item_kind codes
    localparam logic KIND_ENTRY   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // one input word: a face-loop entry with its parallel indices
    typedef struct packed {
        logic signed [REF_W-1:0] point_ref;
        logic signed [REF_W-1:0] param_ref;
        logic signed [REF_W-1:0] normal_ref;
        logic signed [REF_W-1:0] color_ref;
        logic signed [REF_W-1:0] face_ref;
        logic                    stream_end;
    } t_in_word;

    // one buffered entry
    typedef struct packed {
        logic signed [REF_W-1:0] point_ref;
        logic signed [REF_W-1:0] param_ref;
        logic signed [REF_W-1:0] normal_ref;
        logic signed [REF_W-1:0] color_ref;
        logic signed [REF_W-1:0] face_ref;
    } t_mem_word;

    // one output word
    typedef struct packed {
        logic                    item_kind;
        logic signed [REF_W-1:0] out_point;
        logic signed [REF_W-1:0] out_param;
        logic signed [REF_W-1:0] out_normal;
        logic signed [REF_W-1:0] out_color;
        logic signed [REF_W-1:0] out_face;
        logic                    run_last;
        logic [DROP_W-1:0]       dropped_total;
        logic                    overflow_seen;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_READ,
        ST_EMIT,
        ST_TERM,
        ST_SUMMARY
    } t_state;

endpackage

// ----- src/ddf_if.sv -----
// ddf_if: valid/ready channel interfaces for input and output words.
// Depends on ddf_pkg for the payload types.
interface ddf_in_if import ddf_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ddf_out_if import ddf_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/ddf_mem.sv -----
// ddf_mem: facet entry buffer, one write port and one registered read port.
// Depends on ddf_pkg for the entry type.
module ddf_mem import ddf_pkg::*; #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_mem_word     i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_mem_word     o_rdata
);

    t_mem_word r_mem [DEPTH];
    t_mem_word r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/degenerate_facet_filter.sv -----
// degenerate_facet_filter: top level, facet tracking, replay sequencer, output register.
// Depends on ddf_pkg, ddf_if and ddf_mem.
//
// Entries are taken one per cycle while a facet is collected; each stored entry (the
// first one, and later nonzero ones while the facet has room) is written into the entry
// buffer and the run count is updated on the fly. When a facet is decided (zero entry or
// stream_end) a kept facet of n entries is replayed from the buffer, each word by a memory
// read, then an output load, followed by the terminator word and the summary word when
// they apply; no new entry is taken during replay. A dropped facet is not replayed. The
// single read port and the sink pace the replay. Output words wait in a one-word register,
// so input entries are still accepted while a word is held by the sink.
module degenerate_facet_filter import ddf_pkg::*; #(
    parameter int unsigned MAX_FACET = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ddf_in_if.sink           i_in,
    ddf_out_if.source        o_out
);

    localparam int unsigned AW   = $clog2(MAX_FACET);
    localparam int unsigned MC_W = $clog2(MAX_FACET + 2);
    localparam logic [MC_W-1:0] MC_MAX  = MC_W'(MAX_FACET);
    localparam logic [MC_W-1:0] MC_OVF  = MC_W'(MAX_FACET + 1);
    localparam logic [MC_W-1:0] MC_ONE  = MC_W'(1);
    localparam logic [MC_W-1:0] MC_DIST = MC_W'(MIN_DISTINCT);

    t_state r_state, n_state;

    // facet tracking state
    logic [MC_W-1:0]   r_mc, n_mc;
    logic [MC_W-1:0]   r_rc, n_rc;
    logic [REF_W-1:0]  r_first, n_first;
    logic [REF_W-1:0]  r_prev, n_prev;
    logic [DROP_W-1:0] r_drop, n_drop;
    logic              r_ovf, n_ovf;

    // replay control
    logic [MC_W-1:0]   r_len, n_len;
    logic [MC_W-1:0]   r_idx, n_idx;
    logic              r_has_term, n_has_term;
    logic              r_at_end, n_at_end;
    t_mem_word         r_term;

    // output register
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out_word, n_out_word;

    // memory ports
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr;
    t_mem_word         mem_wdata, mem_rdata;

    logic              in_take, slot_free, load_out, last_entry;
    logic              br_first, br_term, br_add, decide, keep;
    logic [REF_W-1:0]  v;
    logic [MC_W-1:0]   u_mc, u_rc, distinct;
    logic [REF_W-1:0]  u_first, u_prev;

    assign in_take    = i_in.valid && i_in.ready;
    assign slot_free  = !r_out_valid || o_out.ready;
    assign last_entry = (r_idx == (r_len - MC_ONE));

    ddf_mem #(
        .DEPTH (MAX_FACET),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    // entry classification and updated facet values
    always_comb begin
        v        = i_in.data.point_ref;
        br_first = (r_mc == '0);
        br_term  = !br_first && (v == '0);
        br_add   = !br_first && (v != '0) && (r_mc < MC_MAX);
        u_mc     = r_mc;
        u_rc     = r_rc;
        u_first  = r_first;
        u_prev   = r_prev;
        if (br_first) begin
            u_mc    = MC_ONE;
            u_rc    = MC_ONE;
            u_first = v;
            u_prev  = v;
        end else if (br_add) begin
            u_mc   = r_mc + MC_ONE;
            u_rc   = (v != r_prev) ? r_rc + MC_ONE : r_rc;
            u_prev = v;
        end else if (!br_term) begin
            u_mc   = MC_OVF;
        end
        // a closing run equal to the first value wraps onto the opening run
        distinct = ((u_rc > MC_ONE) && (u_prev == u_first)) ? u_rc - MC_ONE : u_rc;
        keep     = (u_mc <= MC_MAX) && (distinct >= MC_DIST);
        decide   = br_term || i_in.data.stream_end;
    end

    // buffer write on every stored entry
    always_comb begin
        mem_we    = in_take && (br_first || br_add);
        mem_waddr = br_first ? '0 : r_mc[AW-1:0];
        mem_wdata = '{point_ref:  i_in.data.point_ref,
                      param_ref:  i_in.data.param_ref,
                      normal_ref: i_in.data.normal_ref,
                      color_ref:  i_in.data.color_ref,
                      face_ref:   i_in.data.face_ref};
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_COLLECT: begin
                if (in_take && decide) begin
                    if (keep) begin
                        n_state = ST_READ;
                    end else if (i_in.data.stream_end) begin
                        n_state = ST_SUMMARY;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    if (!last_entry) begin
                        n_state = ST_READ;
                    end else if (r_has_term) begin
                        n_state = ST_TERM;
                    end else if (r_at_end) begin
                        n_state = ST_SUMMARY;
                    end else begin
                        n_state = ST_COLLECT;
                    end
                end
            end
            ST_TERM: begin
                if (slot_free) begin
                    n_state = r_at_end ? ST_SUMMARY : ST_COLLECT;
                end
            end
            ST_SUMMARY: begin
                if (slot_free) begin
                    n_state = ST_COLLECT;
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

    // outputs and register updates per state
    always_comb begin
        i_in.ready  = 1'b0;
        mem_re      = 1'b0;
        load_out    = 1'b0;
        n_out_word  = r_out_word;
        n_mc        = r_mc;
        n_rc        = r_rc;
        n_first     = r_first;
        n_prev      = r_prev;
        n_drop      = r_drop;
        n_ovf       = r_ovf;
        n_len       = r_len;
        n_idx       = r_idx;
        n_has_term  = r_has_term;
        n_at_end    = r_at_end;
        case (r_state)
            ST_COLLECT: begin
                i_in.ready = 1'b1;
                if (in_take) begin
                    n_mc       = u_mc;
                    n_rc       = u_rc;
                    n_first    = u_first;
                    n_prev     = u_prev;
                    n_idx      = '0;
                    n_len      = u_mc;
                    n_has_term = br_term;
                    n_at_end   = i_in.data.stream_end;
                    if (decide) begin
                        n_mc = '0;
                        n_rc = '0;
                        if (!keep) begin
                            if (r_drop != '1) begin
                                n_drop = r_drop + DROP_W'(1);
                            end
                            if (u_mc > MC_MAX) begin
                                n_ovf = 1'b1;
                            end
                        end
                    end
                end
            end
            ST_READ: begin
                mem_re = 1'b1;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    load_out   = 1'b1;
                    n_out_word = '{item_kind:     KIND_ENTRY,
                                   out_point:     mem_rdata.point_ref,
                                   out_param:     mem_rdata.param_ref,
                                   out_normal:    mem_rdata.normal_ref,
                                   out_color:     mem_rdata.color_ref,
                                   out_face:      mem_rdata.face_ref,
                                   run_last:      last_entry && !r_has_term && !r_at_end,
                                   dropped_total: '0,
                                   overflow_seen: 1'b0};
                    n_idx      = r_idx + MC_ONE;
                end
            end
            ST_TERM: begin
                if (slot_free) begin
                    load_out   = 1'b1;
                    n_out_word = '{item_kind:     KIND_ENTRY,
                                   out_point:     '0,
                                   out_param:     r_term.param_ref,
                                   out_normal:    r_term.normal_ref,
                                   out_color:     r_term.color_ref,
                                   out_face:      r_term.face_ref,
                                   run_last:      !r_at_end,
                                   dropped_total: '0,
                                   overflow_seen: 1'b0};
                end
            end
            ST_SUMMARY: begin
                if (slot_free) begin
                    load_out   = 1'b1;
                    n_out_word = '{item_kind:     KIND_SUMMARY,
                                   out_point:     '0,
                                   out_param:     '0,
                                   out_normal:    '0,
                                   out_color:     '0,
                                   out_face:      '0,
                                   run_last:      1'b1,
                                   dropped_total: r_drop,
                                   overflow_seen: r_ovf};
                    // a new stream starts with clean totals
                    n_drop     = '0;
                    n_ovf      = 1'b0;
                end
            end
            default: begin
            end
        endcase
        n_out_valid = load_out || (r_out_valid && !o_out.ready);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_COLLECT;
            r_mc        <= '0;
            r_rc        <= '0;
            r_first     <= '0;
            r_prev      <= '0;
            r_drop      <= '0;
            r_ovf       <= 1'b0;
            r_len       <= '0;
            r_idx       <= '0;
            r_has_term  <= 1'b0;
            r_at_end    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mc        <= n_mc;
            r_rc        <= n_rc;
            r_first     <= n_first;
            r_prev      <= n_prev;
            r_drop      <= n_drop;
            r_ovf       <= n_ovf;
            r_len       <= n_len;
            r_idx       <= n_idx;
            r_has_term  <= n_has_term;
            r_at_end    <= n_at_end;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
        if (in_take) begin
            r_term <= mem_wdata;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_word;

    // open facet count never passes the overflow mark
    a_mc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mc <= MC_OVF)
        else $error("facet member count out of range");

    // replay only runs over a kept, in-buffer facet
    a_replay_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ || r_state == ST_EMIT) |-> (r_len != '0 && r_len <= MC_MAX
            && r_idx < r_len))
        else $error("replay index outside the buffered facet");

    // a stream end always closes the open facet
    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && i_in.data.stream_end) |=> (r_mc == '0 && r_rc == '0))
        else $error("facet left open after stream end");

    // totals clear once the summary word is loaded
    a_sum_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUMMARY && slot_free) |=> (r_drop == '0 && !r_ovf
            && r_out_word.item_kind == KIND_SUMMARY))
        else $error("totals not cleared after summary");

    // no input is taken while the buffer is being replayed
    a_no_take_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_COLLECT) |-> !in_take)
        else $error("entry accepted during replay");

endmodule
